FILE: hw/rtl/dpc_pkg.sv
package dpc_pkg;

  // Ticks that make one second of on time.
  localparam int unsigned TICKS_PER_SECOND = 1000;
  // Width of the internal pulse count; the result shows its low 32 bits.
  localparam int unsigned COUNT_WIDTH = 32;
  // The millisecond counter holds at most TICKS_PER_SECOND; its increment reaches TICKS_PER_SECOND + 1.
  localparam int unsigned MILLIS_W = $clog2(TICKS_PER_SECOND + 2);
  // Width at which the count is compared with max_count.
  localparam int unsigned CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  localparam int unsigned ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_COUNT_HIGH_LEVEL = 2'd0,
    REG_MIN_SETTLE_TICKS = 2'd1,
    REG_MAX_COUNT        = 2'd2,
    REG_UNUSED           = 2'd3
  } reg_idx_t;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_CLEAR = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic        count_high_level;
    logic [15:0] min_settle_ticks;
    logic [31:0] max_count;
    logic        pol_wr;
    logic        pol_val;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pulse_count;
    logic [31:0] on_seconds;
    logic        raw_level;
    logic        stable_level;
  } res_t;

endpackage

FILE: hw/rtl/dpc_cfg.sv
module dpc_cfg
  import dpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  logic        chl_r;
  logic [15:0] settle_r;
  logic [31:0] max_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign idx   = reg_idx_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chl_r    <= 1'b1;
      settle_r <= '0;
      max_r    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_COUNT_HIGH_LEVEL: chl_r    <= pwdata[0];
        REG_MIN_SETTLE_TICKS: settle_r <= pwdata[15:0];
        REG_MAX_COUNT:        max_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COUNT_HIGH_LEVEL: prdata = {31'd0, chl_r};
      REG_MIN_SETTLE_TICKS: prdata = {16'd0, settle_r};
      REG_MAX_COUNT:        prdata = max_r;
      default:              prdata = '0;
    endcase
  end

  // A polarity write also reloads the raw level and edge state in the core.
  assign cfg.count_high_level = chl_r;
  assign cfg.min_settle_ticks = settle_r;
  assign cfg.max_count        = max_r;
  assign cfg.pol_wr           = wr_en && (idx == REG_COUNT_HIGH_LEVEL);
  assign cfg.pol_val          = pwdata[0];

endmodule

FILE: hw/rtl/dpc_core.sv
module dpc_core
  import dpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        proc,
  input  logic        kind,
  input  logic        level,
  input  logic [31:0] clear_value,
  input  cfg_t        cfg,
  output res_t        res
);

  logic                   last_level_r, last_level_nxt;
  logic                   settled_level_r, settled_level_nxt;
  logic                   edge_rise_r, edge_rise_nxt;
  logic                   settled_flag_r, settled_flag_nxt;
  logic [15:0]            timer_r, timer_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [MILLIS_W-1:0]    millis_r, millis_nxt;
  logic [31:0]            secs_r, secs_nxt;
  logic [MILLIS_W-1:0]    millis_inc;
  logic                   at_max;

  assign millis_inc = millis_r + MILLIS_W'(1);
  assign at_max     = CMP_W'(count_r) >= CMP_W'(cfg.max_count);

  always_comb begin
    last_level_nxt    = last_level_r;
    settled_level_nxt = settled_level_r;
    edge_rise_nxt     = edge_rise_r;
    settled_flag_nxt  = settled_flag_r;
    timer_nxt         = timer_r;
    count_nxt         = count_r;
    millis_nxt        = millis_r;
    secs_nxt          = secs_r;
    if (cfg.pol_wr) begin
      last_level_nxt = cfg.pol_val;
      edge_rise_nxt  = ~cfg.pol_val;
    end else if (proc) begin
      if (kind == KIND_CLEAR) begin
        count_nxt        = COUNT_WIDTH'(clear_value);
        last_level_nxt   = cfg.count_high_level;
        edge_rise_nxt    = ~cfg.count_high_level;
        millis_nxt       = '0;
        secs_nxt         = '0;
        timer_nxt        = '0;
        settled_flag_nxt = 1'b0;
      end else if (level != last_level_r) begin
        // Level change: restart the settle timer and note the edge.
        timer_nxt        = '0;
        settled_flag_nxt = 1'b0;
        edge_rise_nxt    = ~last_level_r;
        last_level_nxt   = level;
      end else if (!settled_flag_r) begin
        if (timer_r >= cfg.min_settle_ticks) begin
          settled_level_nxt = last_level_r;
          if (edge_rise_r == cfg.count_high_level) begin
            count_nxt = at_max ? COUNT_WIDTH'(1) : count_r + COUNT_WIDTH'(1);
          end
          timer_nxt        = '0;
          settled_flag_nxt = 1'b1;
        end else begin
          timer_nxt = timer_r + 16'd1;
        end
      end else if (edge_rise_r) begin
        // The counter only ever passes the limit by one, leaving one tick.
        if (millis_inc > MILLIS_W'(TICKS_PER_SECOND)) begin
          secs_nxt   = secs_r + 32'd1;
          millis_nxt = MILLIS_W'(1);
        end else begin
          millis_nxt = millis_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r    <= 1'b0;
      settled_level_r <= 1'b0;
      edge_rise_r     <= 1'b0;
      settled_flag_r  <= 1'b0;
      timer_r         <= '0;
      count_r         <= '0;
      millis_r        <= '0;
      secs_r          <= '0;
    end else begin
      last_level_r    <= last_level_nxt;
      settled_level_r <= settled_level_nxt;
      edge_rise_r     <= edge_rise_nxt;
      settled_flag_r  <= settled_flag_nxt;
      timer_r         <= timer_nxt;
      count_r         <= count_nxt;
      millis_r        <= millis_nxt;
      secs_r          <= secs_nxt;
    end
  end

  // Result of the item being processed, as the state stands after it.
  assign res.pulse_count  = 32'(count_nxt);
  assign res.on_seconds   = secs_nxt;
  assign res.raw_level    = last_level_nxt;
  assign res.stable_level = settled_level_nxt;

endmodule

FILE: hw/rtl/debounced_pulse_counter_core.sv
// Channel   Handshake              Payload
// -------   --------------------   -------------------------------------------
// input     in_valid / in_ready    in_kind, in_pin_level, in_clear_value
// result    out_valid / out_ready  out_pulse_count, out_on_seconds,
//                                  out_raw_level, out_stable_level
// config    psel/penable/pwrite    paddr, pwdata, prdata, pready (always high)
//
// Each item waits in the input register and is processed as it moves into
// the result register, which raises out_valid; the move waits while the
// result register holds a result that has not been taken.
// One item is taken every cycle while the result side drains.
// rst_n is synchronous and active low; it clears all counters, levels and
// valid flags and restores the register defaults.
// A stalled result holds its register; the input register then holds its
// item, and in_ready falls only once both stages are occupied.
module debounced_pulse_counter_core
  import dpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic              in_pin_level,
  input  logic [31:0]       in_clear_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_pulse_count,
  output logic [31:0]       out_on_seconds,
  output logic              out_raw_level,
  output logic              out_stable_level,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Input register: holds one accepted item until the core processes it.
  logic        in_vld_r;
  logic        kind_r;
  logic        level_r;
  logic [31:0] cval_r;
  // Result register.
  logic        out_vld_r, out_vld_nxt;
  res_t        res_r;
  res_t        res;
  cfg_t        cfg;
  logic        proc;

  // The item in the input register is processed whenever the result
  // register is empty or is being emptied in this cycle.
  assign proc     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || proc;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= in_kind;
      level_r <= in_pin_level;
      cval_r  <= in_clear_value;
    end
  end

  dpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  dpc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .proc        (proc),
    .kind        (kind_r),
    .level       (level_r),
    .clear_value (cval_r),
    .cfg         (cfg),
    .res         (res)
  );

  always_comb begin
    if (proc) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pulse_count  = res_r.pulse_count;
  assign out_on_seconds   = res_r.on_seconds;
  assign out_raw_level    = res_r.raw_level;
  assign out_stable_level = res_r.stable_level;

endmodule
